// File: rtl/wsb64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder package
// Widths, the alphabet lookup and shared types for the web-safe decoder.
// ----------------------------------------------------------------------------
package wsb64_pkg;

    localparam int CHAR_W = 8;
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 12;
    localparam int PEND_W = 4;
    localparam int SEXT_W = 6;

    localparam logic [PEND_W-1:0] BITS_PER_CHAR = PEND_W'(SEXT_W);
    localparam logic [PEND_W-1:0] BITS_PER_BYTE = PEND_W'(BYTE_W);

    localparam logic [CHAR_W-1:0] CH_PAD = 8'h3D;

    typedef struct packed {
        logic              hit;
        logic [SEXT_W-1:0] val;
    } t_sextet;

    // Both the standard and the URL-safe alphabets map to the same values.
    function automatic t_sextet sextet_of(input logic [CHAR_W-1:0] c);
        t_sextet s;
        s.hit = 1'b1;
        s.val = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.val = SEXT_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.val = SEXT_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.val = SEXT_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B || c == 8'h2D) begin
            s.val = SEXT_W'(62);
        end else if (c == 8'h2F || c == 8'h5F) begin
            s.val = SEXT_W'(63);
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

// File: rtl/wsb64_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder channels
// Valid/ready channels for encoded characters and decoded bytes.
// ----------------------------------------------------------------------------
interface wsb64_char_if;
    import wsb64_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              end_of_string;

    modport source (output valid, output in_char, output end_of_string, input ready);
    modport sink (input valid, input in_char, input end_of_string, output ready);
endinterface

interface wsb64_byte_if;
    import wsb64_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic              string_done;

    modport source (output valid, output byte_out, output byte_valid, output string_done,
                    input ready);
    modport sink (input valid, input byte_out, input byte_valid, input string_done,
                  output ready);
endinterface

// File: rtl/websafe_base64_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Web-safe base64 decoder
// Decodes one character per transfer into at most one byte per transfer.
// ----------------------------------------------------------------------------
//  Channel  Port     Direction  Payload
//  chars    i_chr    sink       in_char, end_of_string
//  bytes    o_byt    source     byte_out, byte_valid, string_done
//
//  A character is registered on input, then decoded into the result register.
//  One character is taken every cycle while the result side keeps up; the
//  decoder state is updated in the decode stage, which sets that rate.
//  A stall on the result side holds both stages. Reset clears the state.
// ----------------------------------------------------------------------------
module websafe_base64_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wsb64_char_if.sink   i_chr,
    wsb64_byte_if.source o_byt
);
    import wsb64_pkg::*;

    logic              r_s1_vld;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_eos;

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_pad, n_pad;

    logic              r_out_vld;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_bval, n_bval;
    logic              r_done;

    logic              advance;
    logic              fire;
    t_sextet           sx;
    logic [ACC_W-1:0]  acc_sh;
    logic [PEND_W-1:0] pend_add;
    logic [PEND_W-1:0] shamt;

    assign advance     = !r_out_vld || o_byt.ready;
    assign fire        = r_s1_vld && advance;
    assign i_chr.ready = !r_s1_vld || advance;

    assign sx       = sextet_of(r_s1_char);
    assign acc_sh   = {r_acc[ACC_W-SEXT_W-1:0], sx.val};
    assign pend_add = r_pend + BITS_PER_CHAR;
    assign shamt    = pend_add - BITS_PER_BYTE;

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        n_pad  = r_pad;
        n_byte = '0;
        n_bval = 1'b0;
        if (!r_pad) begin
            if (r_s1_char == CH_PAD) begin
                n_pad = 1'b1;
            end else if (sx.hit) begin
                n_acc  = acc_sh;
                n_pend = pend_add;
                if (pend_add >= BITS_PER_BYTE) begin
                    n_bval = 1'b1;
                    n_pend = shamt;
                    unique case (shamt)
                        PEND_W'(0): n_byte = acc_sh[7:0];
                        PEND_W'(2): n_byte = acc_sh[9:2];
                        default:    n_byte = acc_sh[11:4];
                    endcase
                end
            end
        end
        if (r_s1_eos) begin
            n_acc  = '0;
            n_pend = '0;
            n_pad  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            r_pend    <= '0;
            r_pad     <= 1'b0;
        end else begin
            if (i_chr.ready) begin
                r_s1_vld <= i_chr.valid;
            end
            if (advance) begin
                r_out_vld <= r_s1_vld;
            end
            if (fire) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_pad  <= n_pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chr.ready && i_chr.valid) begin
            r_s1_char <= i_chr.in_char;
            r_s1_eos  <= i_chr.end_of_string;
        end
        if (fire) begin
            r_byte <= n_byte;
            r_bval <= n_bval;
            r_done <= r_s1_eos;
        end
    end

    assign o_byt.valid       = r_out_vld;
    assign o_byt.byte_out    = r_byte;
    assign o_byt.byte_valid  = r_bval;
    assign o_byt.string_done = r_done;

    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend[0] && r_pend <= BITS_PER_CHAR)
        else $error("pending bit count out of range");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_s1_eos |=> r_pend == '0 && !r_pad && r_acc == '0)
        else $error("state not cleared after end of string");

    a_pad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_pad |=> !r_bval)
        else $error("byte produced after padding");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_bval |-> r_byte == '0)
        else $error("nonzero byte without byte_valid");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_byt.ready |=> r_out_vld && $stable(r_pend) && $stable(r_acc))
        else $error("state moved during result stall");

endmodule
